// ===== hw/rtl/grdz_pkg.sv =====
`default_nettype none
package grdz_pkg;

	localparam int unsigned CompW = 16;
	localparam int unsigned DzW = 15;
	localparam logic [DzW-1:0] DzReset = 15'd8192;
	localparam logic [DzW-1:0] DzMax = 15'd32766;
	localparam logic [DzW-1:0] FullScale = 15'd32767;
	localparam int unsigned SqW = 32;
	localparam int unsigned RootW = 24;
	localparam int unsigned QuotW = 16;
	localparam int unsigned NumW = 55;

	typedef struct packed {
		logic [15:0] buttons;
		logic [7:0] left_trigger;
		logic [7:0] right_trigger;
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
	} in_item_t;

	typedef struct packed {
		logic changed;
		logic active;
		logic signed [15:0] left_x_out;
		logic signed [15:0] left_y_out;
		logic signed [15:0] right_x_out;
		logic signed [15:0] right_y_out;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SQRT,
		ST_DEN,
		ST_COMP,
		ST_DIV,
		ST_STORE,
		ST_NEXT,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic sqrt_step;
		logic den_calc;
		logic comp_load;
		logic div_step;
		logic comp_store;
		logic finish;
		logic stick_sel;
		logic comp_sel;
	} cmd_t;

	typedef struct packed {
		logic outside;
		logic sqrt_done;
		logic div_done;
	} sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/grdz_ctrl.sv =====
`default_nettype none
module grdz_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire grdz_pkg::sts_t sts,
	output grdz_pkg::cmd_t cmd
);
	import grdz_pkg::*;

	state_t state_q, state_nx;
	logic stick_q, stick_nx;
	logic comp_q, comp_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stick_q <= 1'b0;
			comp_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			stick_q <= stick_nx;
			comp_q <= comp_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		stick_nx = stick_q;
		comp_nx = comp_q;
		cmd = '0;
		cmd.stick_sel = stick_q;
		cmd.comp_sel = comp_q;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					stick_nx = 1'b0;
					state_nx = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				comp_nx = 1'b0;
				state_nx = ST_SQRT;
			end
			ST_SQRT: begin
				if (!sts.outside) begin
					state_nx = ST_NEXT;
				end else begin
					cmd.sqrt_step = 1'b1;
					if (sts.sqrt_done) state_nx = ST_DEN;
				end
			end
			ST_DEN: begin
				cmd.den_calc = 1'b1;
				state_nx = ST_COMP;
			end
			ST_COMP: begin
				cmd.comp_load = 1'b1;
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_nx = ST_STORE;
			end
			ST_STORE: begin
				cmd.comp_store = 1'b1;
				if (comp_q) begin
					state_nx = ST_NEXT;
				end else begin
					comp_nx = 1'b1;
					state_nx = ST_COMP;
				end
			end
			ST_NEXT: begin
				if (stick_q) begin
					state_nx = ST_FINISH;
				end else begin
					stick_nx = 1'b1;
					state_nx = ST_SETUP;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	a_out_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT)
		else $error("result shown outside output state");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("item taken while result pending");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finish not followed by result");

endmodule
`default_nettype wire

// ===== hw/rtl/grdz_dp.sv =====
`default_nettype none
module grdz_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic deadzone_we,
	input wire logic [grdz_pkg::DzW-1:0] deadzone_wdata,
	input wire grdz_pkg::in_item_t in_item,
	input wire grdz_pkg::cmd_t cmd,
	output grdz_pkg::sts_t sts,
	output grdz_pkg::out_item_t out_item
);
	import grdz_pkg::*;

	logic [DzW-1:0] dz_q;
	logic [15:0] prev_buttons_q;
	logic [7:0] prev_lt_q, prev_rt_q;
	logic [CompW-1:0] prev_lx_q, prev_ly_q, prev_rx_q, prev_ry_q;
	logic prev_active_q;
	in_item_t item_q;
	logic [CompW-1:0] res_lx_q, res_ly_q, res_rx_q, res_ry_q;
	logic stick_chg_q;
	logic judge_q;
	logic changed_q, active_q;

	logic [DzW-1:0] dz_eff;
	logic signed [CompW-1:0] cx, cy, px, py;
	logic [CompW-1:0] ax, ay;
	logic [SqW:0] s_now, ps_now;
	logic [SqW-1:0] d2_now;

	logic [SqW:0] s_q;
	logic [SqW-1:0] d2_q;
	logic outside_q, chg_in_q;

	logic [49:0] rem_q;
	logic [RootW-1:0] root_q;
	logic [RootW+1:0] srem_q;
	logic [4:0] scnt_q;

	logic [RootW:0] lmd_q;
	logic [RootW+DzW:0] den_q;
	logic [NumW-1:0] num_q;
	logic [NumW-1:0] drem_q;
	logic [QuotW:0] quo_q;
	logic [5:0] dcnt_q;
	logic neg_q;
	logic [CompW-1:0] ac;
	logic [RootW+CompW:0] p1_q;
	logic [1:0] mstep_q;
	logic [NumW:0] dtrial;
	logic [QuotW:0] rq;
	logic [CompW-1:0] sat;

	assign dz_eff = (dz_q > DzMax) ? DzMax : dz_q;

	always_comb begin
		cx = cmd.stick_sel ? item_q.right_x : item_q.left_x;
		cy = cmd.stick_sel ? item_q.right_y : item_q.left_y;
		px = cmd.stick_sel ? prev_rx_q : prev_lx_q;
		py = cmd.stick_sel ? prev_ry_q : prev_ly_q;
	end

	assign ax = cx[15] ? CompW'(-cx) : cx;
	assign ay = cy[15] ? CompW'(-cy) : cy;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			s_q <= (SqW+1)'(32'(ax) * 32'(ax)) + (SqW+1)'(32'(ay) * 32'(ay));
		end
	end

	always_comb begin
		logic [CompW-1:0] apx, apy;
		apx = px[15] ? CompW'(-px) : px;
		apy = py[15] ? CompW'(-py) : py;
		ps_now = (SqW+1)'(32'(apx) * 32'(apx)) + (SqW+1)'(32'(apy) * 32'(apy));
		d2_now = 32'(dz_eff) * 32'(dz_eff);
		s_now = s_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outside_q <= 1'b0;
			chg_in_q <= 1'b0;
			d2_q <= '0;
		end else if (cmd.setup) begin
			outside_q <= 1'b0;
			chg_in_q <= 1'b0;
			d2_q <= d2_now;
		end else if (cmd.sqrt_step && scnt_q == 5'd0) begin
			outside_q <= s_now > {1'b0, d2_q};
			chg_in_q <= ps_now > {1'b0, d2_q} && s_now < {1'b0, d2_q};
		end
	end

	// sqrt of s<<16 (50 bits -> 25-bit root, fits 24), one bit per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scnt_q <= '0;
		end else if (cmd.setup) begin
			scnt_q <= '0;
		end else if (cmd.sqrt_step) begin
			scnt_q <= scnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		logic [RootW+3:0] r2;
		logic [RootW+3:0] t;
		if (cmd.setup) begin
			rem_q <= '0;
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step && scnt_q == 5'd0) begin
			rem_q <= {1'b0, s_now, 16'd0};
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step) begin
			r2 = {srem_q, rem_q[49:48]};
			t = {2'b00, root_q, 2'b01};
			if (r2 >= t) begin
				srem_q <= (RootW+2)'(r2 - t);
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				srem_q <= r2[RootW+1:0];
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
			rem_q <= {rem_q[47:0], 2'b00};
		end else if (cmd.den_calc) begin
			lmd_q <= (RootW+1)'(root_q) - (RootW+1)'({dz_eff, 8'd0});
			den_q <= (RootW+DzW+1)'(root_q) * (RootW+DzW+1)'(FullScale - dz_eff);
		end
	end

	assign sts.outside = (scnt_q == 5'd0) ? 1'b1 : outside_q;
	assign sts.sqrt_done = (scnt_q == 5'd25);

	assign ac = cmd.comp_sel ? ay : ax;
	assign dtrial = {1'b0, drem_q[NumW-2:0], num_q[NumW-1]} - {1'b0, den_q} ;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			mstep_q <= '0;
		end else if (cmd.comp_load) begin
			dcnt_q <= '0;
			mstep_q <= '0;
		end else if (cmd.div_step) begin
			if (mstep_q != 2'd2) mstep_q <= mstep_q + 2'd1;
			else dcnt_q <= dcnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.comp_load) begin
			neg_q <= cmd.comp_sel ? cy[15] : cx[15];
			p1_q <= (RootW+CompW+1)'(ac) * (RootW+CompW+1)'(lmd_q);
		end else if (cmd.div_step && mstep_q == 2'd0) begin
			num_q <= (NumW'(p1_q) << DzW) - NumW'(p1_q);
		end else if (cmd.div_step && mstep_q == 2'd1) begin
			num_q <= num_q + NumW'(den_q >> 1);
			drem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (!dtrial[NumW]) begin
				drem_q <= NumW'(dtrial);
				quo_q <= {quo_q[QuotW-1:0], 1'b1} | ((QuotW+1)'(|quo_q[QuotW:QuotW-1]) << QuotW);
			end else begin
				drem_q <= {drem_q[NumW-2:0], num_q[NumW-1]};
				quo_q <= {quo_q[QuotW-1:0], 1'b0} | ((QuotW+1)'(|quo_q[QuotW:QuotW-1]) << QuotW);
			end
			num_q <= {num_q[NumW-2:0], 1'b0};
		end
	end

	assign sts.div_done = (mstep_q == 2'd2) && (dcnt_q == 6'(NumW - 1));
	assign rq = quo_q;
	assign sat = (rq > (QuotW+1)'(FullScale)) ? CompW'(FullScale) : rq[CompW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			if (cmd.stick_sel) begin
				res_rx_q <= '0;
				res_ry_q <= '0;
			end else begin
				res_lx_q <= '0;
				res_ly_q <= '0;
			end
		end else if (cmd.comp_store) begin
			unique case ({cmd.stick_sel, cmd.comp_sel})
				2'b00: res_lx_q <= neg_q ? CompW'(-sat) : sat;
				2'b01: res_ly_q <= neg_q ? CompW'(-sat) : sat;
				2'b10: res_rx_q <= neg_q ? CompW'(-sat) : sat;
				default: res_ry_q <= neg_q ? CompW'(-sat) : sat;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_chg_q <= 1'b0;
			judge_q <= 1'b0;
		end else begin
			judge_q <= cmd.sqrt_step && scnt_q == 5'd0;
			if (cmd.load) begin
				stick_chg_q <= 1'b0;
			end else if (judge_q) begin
				stick_chg_q <= stick_chg_q | outside_q | chg_in_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= DzReset;
			prev_buttons_q <= '0;
			prev_lt_q <= '0;
			prev_rt_q <= '0;
			prev_lx_q <= '0;
			prev_ly_q <= '0;
			prev_rx_q <= '0;
			prev_ry_q <= '0;
			prev_active_q <= 1'b0;
			changed_q <= 1'b0;
			active_q <= 1'b0;
		end else begin
			if (deadzone_we) dz_q <= deadzone_wdata;
			if (cmd.finish) begin
				logic act;
				act = stick_chg_q || item_q.buttons != prev_buttons_q
					|| item_q.left_trigger != prev_lt_q || item_q.right_trigger != prev_rt_q;
				active_q <= act;
				changed_q <= act || (act != prev_active_q);
				prev_active_q <= act;
				prev_buttons_q <= item_q.buttons;
				prev_lt_q <= item_q.left_trigger;
				prev_rt_q <= item_q.right_trigger;
				prev_lx_q <= res_lx_q;
				prev_ly_q <= res_ly_q;
				prev_rx_q <= res_rx_q;
				prev_ry_q <= res_ry_q;
			end
		end
	end

	always_comb begin
		out_item.changed = changed_q;
		out_item.active = active_q;
		out_item.left_x_out = res_lx_q;
		out_item.left_y_out = res_ly_q;
		out_item.right_x_out = res_rx_q;
		out_item.right_y_out = res_ry_q;
	end

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.comp_store |-> sat <= CompW'(FullScale))
		else $error("component above full scale");
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		dz_eff <= DzMax)
		else $error("deadzone limit broken");
	a_zero_in: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.den_calc |-> outside_q)
		else $error("rescale of stick inside deadzone");

endmodule
`default_nettype wire

// ===== hw/rtl/gamepad_radial_deadzone_change_detect.sv =====
`default_nettype none
// Gamepad poll conditioner: one item in, one result out, one item at a time.
// A stick inside the deadzone gives zero; one outside takes a
// bit-serial square root, then for each component a rescale built
// around a 55-step bit-serial divide. The item is taken, both sticks are
// worked in turn, the result is finished and then shown until the output
// is not stalled; the root and divide units are shared by all of it. Write deadzone
// only while idle.
module gamepad_radial_deadzone_change_detect (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [grdz_pkg::DzW-1:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire grdz_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output grdz_pkg::out_item_t out_data
);
	import grdz_pkg::*;

	cmd_t cmd;
	sts_t sts;

	grdz_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .cmd(cmd)
	);

	grdz_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.deadzone_we(cfg_we), .deadzone_wdata(cfg_wdata),
		.in_item(in_data), .cmd(cmd), .sts(sts), .out_item(out_data)
	);

endmodule
`default_nettype wire
